FILE: rtl/nso_pkg.sv
package nso_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int STEP_BITS      = 4;
  localparam int SEQUENCE_STEPS = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUARTER    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_SLOT0  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_SLOT1  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_SLOT3  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_SLOT5  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENV_RATE   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUARTER_RECIP = 3'd7;

  localparam logic [1:0] MODE_SILENT = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_ENV    = 2'd2;
  localparam logic [1:0] MODE_GLIDE  = 2'd3;

  localparam logic [2:0] SLOT_0 = 3'd0;
  localparam logic [2:0] SLOT_1 = 3'd1;
  localparam logic [2:0] SLOT_3 = 3'd3;
  localparam logic [2:0] SLOT_5 = 3'd5;

  localparam logic [2:0] NOTE_SLOT [SEQUENCE_STEPS] = '{
    SLOT_0, SLOT_1, SLOT_3, SLOT_1, SLOT_0, SLOT_1, SLOT_5, SLOT_1
  };

  localparam logic [16:0] ENV_ONE = 17'h10000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL1   = 5'b00010,
    ST_MUL2   = 5'b00100,
    ST_MUL3   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

endpackage

FILE: rtl/nso_rom.sv
module nso_rom #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int ADDR_BITS   = 10
) (
  input  logic                          clk,
  input  logic [ADDR_BITS-1:0]          addr,
  output logic signed [SAMPLE_BITS-1:0] data
);

  localparam longint unsigned AMP = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // quarter-wave Taylor series in Q2.30, terms through x^11
  function automatic logic [SAMPLE_BITS-1:0] sine_entry(input longint unsigned i);
    longint unsigned p;
    longint unsigned q;
    longint unsigned r;
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    p    = i * 64'd4;
    q    = p / DEPTH;
    r    = p % DEPTH;
    a    = q[0] ? DEPTH - r : r;
    x    = a * nso_pkg::HALF_PI_Q30 / DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * AMP + (64'd1 << 29)) >> 30;
    if (v > AMP) begin
      v = AMP;
    end
    if (q >= 64'd2) begin
      v = -v;
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  logic signed [SAMPLE_BITS-1:0] rom [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = sine_entry(longint'(g));
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

FILE: rtl/nso_ctrl.sv
module nso_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output nso_pkg::cmd_t  cmd
);

  nso_pkg::state_t state;
  nso_pkg::state_t state_next;
  logic            out_free;
  logic            m_tvalid_next;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == nso_pkg::ST_IDLE) ||
                    ((state == nso_pkg::ST_FINISH) && out_free);
  assign cmd.accept = s_tvalid && s_tready;
  assign cmd.commit = (state == nso_pkg::ST_FINISH) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      nso_pkg::ST_IDLE: begin
        if (cmd.accept) state_next = nso_pkg::ST_MUL1;
      end
      nso_pkg::ST_MUL1: state_next = nso_pkg::ST_MUL2;
      nso_pkg::ST_MUL2: state_next = nso_pkg::ST_MUL3;
      nso_pkg::ST_MUL3: state_next = nso_pkg::ST_FINISH;
      nso_pkg::ST_FINISH: begin
        if (out_free) state_next = cmd.accept ? nso_pkg::ST_MUL1 : nso_pkg::ST_IDLE;
      end
      default: state_next = nso_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.commit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= nso_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

FILE: rtl/nso_dp.sv
module nso_dp #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nso_pkg::cmd_t                        cmd,
  input  logic                                 restart,
  input  logic                                 cfg_we,
  input  logic [nso_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [nso_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic signed [SAMPLE_BITS-1:0]        sample_value,
  output logic [nso_pkg::STEP_BITS-1:0]        step_number,
  output logic                                 silent
);

  localparam int P = PHASE_BITS;
  localparam int S = SAMPLE_BITS;
  localparam int A = $clog2(SINE_TABLE_DEPTH);
  localparam logic [A:0] DEPTH_W = (A + 1)'(SINE_TABLE_DEPTH);

  // configuration
  logic [1:0]  mode;
  logic [15:0] quarter_cfg;
  logic [31:0] inc_slot0;
  logic [31:0] inc_slot1;
  logic [31:0] inc_slot3;
  logic [31:0] inc_slot5;
  logic [15:0] env_rate;
  logic [15:0] quarter_recip;

  // time state
  logic [P-1:0]                  phase;
  logic [19:0]                   elapsed;
  logic [15:0]                   step_count;
  logic [nso_pkg::STEP_BITS-1:0] step;

  logic        mode_change;
  logic        clear;
  logic        finished;
  logic [15:0] quarter;
  logic [2:0]  step_lo;
  logic [2:0]  step_nx;
  logic [31:0] raw_a;
  logic [31:0] raw_b;
  logic [P-1:0] inc_a;
  logic [P-1:0] inc_b;

  function automatic logic [31:0] slot_inc(input logic [2:0] slot,
                                           input logic [31:0] i0,
                                           input logic [31:0] i1,
                                           input logic [31:0] i3,
                                           input logic [31:0] i5);
    logic [31:0] r;
    case (slot)
      nso_pkg::SLOT_0: r = i0;
      nso_pkg::SLOT_1: r = i1;
      nso_pkg::SLOT_3: r = i3;
      default:         r = i5;
    endcase
    return r;
  endfunction

  assign mode_change = cfg_we && (cfg_index == nso_pkg::REG_MODE) && (cfg_data[1:0] != mode);
  assign clear       = mode_change || (cmd.accept && restart);
  assign finished    = step >= nso_pkg::STEP_BITS'(nso_pkg::SEQUENCE_STEPS);
  assign quarter     = (quarter_cfg == 16'd0) ? 16'd1 : quarter_cfg;
  assign step_lo     = step[2:0];
  assign step_nx     = step_lo + 3'd1;
  assign raw_a = slot_inc(nso_pkg::NOTE_SLOT[step_lo], inc_slot0, inc_slot1, inc_slot3, inc_slot5);
  assign raw_b = slot_inc(nso_pkg::NOTE_SLOT[step_nx], inc_slot0, inc_slot1, inc_slot3, inc_slot5);

  if (P >= 32) begin : g_inc_wide
    assign inc_a = P'(raw_a) << (P - 32);
    assign inc_b = P'(raw_b) << (P - 32);
  end else begin : g_inc_narrow
    assign inc_a = P'(raw_a >> (32 - P));
    assign inc_b = P'(raw_b >> (32 - P));
  end

  // stage 1: products from the time state
  logic [P+19:0] pop_prod;
  logic [22:0]   s5;
  logic [21:0]   q39;
  logic [22:0]   fall_dist;

  logic [P-1:0] s1_pop_phase;
  logic [35:0]  s1_up;
  logic [38:0]  s1_dn;
  logic [31:0]  s1_frac;
  logic         s1_rise;
  logic         s1_fall;
  logic [P-1:0] s1_inc_a;
  logic [P-1:0] s1_absdiff;
  logic         s1_b_ge;

  assign pop_prod  = elapsed * inc_a;
  assign s5        = {1'b0, elapsed, 2'b00} + {3'b000, elapsed};
  assign q39       = {quarter, 5'b00000} + {3'b000, quarter, 3'b000} - {6'b0, quarter};
  assign fall_dist = s5 - {1'b0, q39};

  always_ff @(posedge clk) begin
    s1_pop_phase <= pop_prod[P-1:0];
    s1_up        <= elapsed * env_rate;
    s1_dn        <= fall_dist * quarter_recip;
    s1_frac      <= step_count * quarter_recip;
    s1_rise      <= s5 < {7'b0, quarter};
    s1_fall      <= s5 > {1'b0, q39};
    s1_inc_a     <= inc_a;
    s1_b_ge      <= inc_b >= inc_a;
    s1_absdiff   <= (inc_b >= inc_a) ? inc_b - inc_a : inc_a - inc_b;
  end

  // stage 2: envelope, glide product, table address
  logic [16:0]    env;
  logic [16:0]    frac;
  logic [P-1:0]   phase_sel;
  logic [P+A:0]   idx_prod;
  logic [A-1:0]   rom_addr;
  logic signed [S-1:0] rom_data;

  logic [16:0]   s2_env;
  logic [P+16:0] s2_glide;
  logic [P-1:0]  s2_inc_a;
  logic          s2_b_ge;

  always_comb begin
    if (s1_rise) begin
      env = (s1_up > 36'(nso_pkg::ENV_ONE)) ? nso_pkg::ENV_ONE : s1_up[16:0];
    end else if (s1_fall) begin
      env = nso_pkg::ENV_ONE -
            ((s1_dn > 39'(nso_pkg::ENV_ONE)) ? nso_pkg::ENV_ONE : s1_dn[16:0]);
    end else begin
      env = nso_pkg::ENV_ONE;
    end
  end

  assign frac      = (s1_frac > 32'(nso_pkg::ENV_ONE)) ? nso_pkg::ENV_ONE : s1_frac[16:0];
  assign phase_sel = (mode == nso_pkg::MODE_POP) ? s1_pop_phase : phase;
  assign idx_prod  = phase_sel * DEPTH_W;
  assign rom_addr  = idx_prod[P+A-1:P];

  nso_rom #(
    .DEPTH       (SINE_TABLE_DEPTH),
    .SAMPLE_BITS (S),
    .ADDR_BITS   (A)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    s2_env   <= env;
    s2_glide <= s1_absdiff * frac;
    s2_inc_a <= s1_inc_a;
    s2_b_ge  <= s1_b_ge;
  end

  // stage 3: envelope product, final increment
  logic [P-1:0]          glide_step;
  logic signed [S+17:0]  s3_prod;
  logic [P-1:0]          s3_inc;

  assign glide_step = s2_glide[P+15:16];

  always_ff @(posedge clk) begin
    s3_prod <= rom_data * $signed({1'b0, s2_env});
    if (mode == nso_pkg::MODE_GLIDE) begin
      s3_inc <= s2_b_ge ? s2_inc_a + glide_step : s2_inc_a - glide_step;
    end else begin
      s3_inc <= s2_inc_a;
    end
  end

  // stage 4: result and time advance
  logic signed [S+17:0] prod_adj;
  logic signed [S-1:0]  env_value;
  logic signed [S-1:0]  value;
  logic [16:0]          count_inc;

  assign prod_adj  = s3_prod + (S + 18)'(s3_prod[S+17] ? 17'h0FFFF : 17'h00000);
  assign env_value = prod_adj[S+15:16];
  assign count_inc = {1'b0, step_count} + 17'd1;

  always_comb begin
    if ((mode == nso_pkg::MODE_SILENT) || finished) begin
      value = '0;
    end else if (mode == nso_pkg::MODE_POP) begin
      value = rom_data;
    end else begin
      value = env_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample_value <= value;
      step_number  <= step;
      silent       <= (mode == nso_pkg::MODE_SILENT) || finished;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= nso_pkg::MODE_SILENT;
      quarter_cfg   <= 16'd12000;
      inc_slot0     <= '0;
      inc_slot1     <= '0;
      inc_slot3     <= '0;
      inc_slot5     <= '0;
      env_rate      <= '0;
      quarter_recip <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nso_pkg::REG_MODE:          mode          <= cfg_data[1:0];
        nso_pkg::REG_QUARTER:       quarter_cfg   <= cfg_data[15:0];
        nso_pkg::REG_INC_SLOT0:     inc_slot0     <= cfg_data;
        nso_pkg::REG_INC_SLOT1:     inc_slot1     <= cfg_data;
        nso_pkg::REG_INC_SLOT3:     inc_slot3     <= cfg_data;
        nso_pkg::REG_INC_SLOT5:     inc_slot5     <= cfg_data;
        nso_pkg::REG_ENV_RATE:      env_rate      <= cfg_data[15:0];
        nso_pkg::REG_QUARTER_RECIP: quarter_recip <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase      <= '0;
      elapsed    <= '0;
      step_count <= '0;
      step       <= '0;
    end else if (cmd.commit && !finished) begin
      elapsed <= elapsed + 20'd1;
      if (count_inc >= {1'b0, quarter}) begin
        step_count <= '0;
        step       <= step + 4'd1;
      end else begin
        step_count <= count_inc[15:0];
      end
      if ((mode == nso_pkg::MODE_ENV) || (mode == nso_pkg::MODE_GLIDE)) begin
        phase <= phase + s3_inc;
      end
    end
  end

endmodule

FILE: rtl/note_sequence_sine_oscillator.sv
// Each accepted input word runs the four-stage multiply sequence (time products, envelope
// and glide, sine table read and scale, commit) through MUL1, MUL2, MUL3 and FINISH; a new
// word is taken only in IDLE or at that commit, and m_tvalid is registered from the commit.
// A finished word waits in the output register while the next one is computed.
// Reset (rst, synchronous) clears the sequencer, configuration registers and time state;
// the sine table is a constant ROM and needs no fill.
module note_sequence_sine_oscillator #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [0] restart
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [((SAMPLE_BITS + nso_pkg::STEP_BITS + 7) / 8) * 8 - 1:0]
                                             m_tdata,   // sample_value, step_number
  output logic                               m_tuser,   // silent
  input  logic                               cfg_we,
  input  logic [nso_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [nso_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int FIELD_BITS = SAMPLE_BITS + nso_pkg::STEP_BITS;
  localparam int OUT_BITS   = ((FIELD_BITS + 7) / 8) * 8;

  nso_pkg::cmd_t                  cmd;
  logic signed [SAMPLE_BITS-1:0]  sample_value;
  logic [nso_pkg::STEP_BITS-1:0]  step_number;

  nso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  nso_dp #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .restart      (s_tdata[0]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (sample_value),
    .step_number  (step_number),
    .silent       (m_tuser)
  );

  assign m_tdata = OUT_BITS'({step_number, sample_value});

endmodule
